// File: hw/rtl/pbd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbd_pkg
// Types and constants shared by the PEM base64 stream decoder modules.
// ----------------------------------------------------------------------------
package pbd_pkg;

   localparam int unsigned BeginLen = 10;
   localparam int unsigned EndLen   = 6;

   localparam logic [7:0] CharDash    = 8'h2d;
   localparam logic [7:0] CharNewline = 8'h0a;
   localparam logic [7:0] CharPad     = 8'h3d;
   localparam logic [7:0] CharPlus    = 8'h2b;
   localparam logic [7:0] CharSlash   = 8'h2f;

   localparam logic [5:0] SextetPlus  = 6'h3e;
   localparam logic [5:0] SextetSlash = 6'h3f;

   typedef enum logic [1:0] {
      PHASE_SEEK     = 2'd0,
      PHASE_SKIPLINE = 2'd1,
      PHASE_BODY     = 2'd2,
      PHASE_DONE     = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_BEGIN = 2'd1,
      STATUS_NO_END   = 2'd2
   } status_type;

   // Classification of one input byte.
   typedef struct packed {
      logic       is_sextet;
      logic [5:0] sextet;
      logic       is_dash;
      logic       is_newline;
      logic       is_pad;
   } char_class_type;

   // One result produced by the parser for one input byte.
   typedef struct packed {
      logic       present;
      logic       data_valid;
      logic [7:0] out_byte;
      logic       done_res;
      status_type status;
   } result_type;

   // Expected byte of "-----BEGIN" at a given match position.
   function automatic logic [7:0] begin_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd5:    c = 8'h42;  // B
         4'd6:    c = 8'h45;  // E
         4'd7:    c = 8'h47;  // G
         4'd8:    c = 8'h49;  // I
         4'd9:    c = 8'h4e;  // N
         default: c = CharDash;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/pbd_char_class.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbd_char_class
// Maps one byte of text to its base64 six-bit value and marker flags.
// ----------------------------------------------------------------------------
module pbd_char_class (
   input  wire logic [7:0]            char_in,
   output pbd_pkg::char_class_type    char_class
);

   always_comb begin
      char_class            = '0;
      char_class.is_dash    = (char_in == pbd_pkg::CharDash);
      char_class.is_newline = (char_in == pbd_pkg::CharNewline);
      char_class.is_pad     = (char_in == pbd_pkg::CharPad);
      if (char_in >= 8'h41 && char_in <= 8'h5a) begin
         char_class.is_sextet = 1'b1;
         char_class.sextet    = 6'(char_in - 8'h41);
      end else if (char_in >= 8'h61 && char_in <= 8'h7a) begin
         char_class.is_sextet = 1'b1;
         char_class.sextet    = 6'(char_in - 8'h61 + 8'd26);
      end else if (char_in >= 8'h30 && char_in <= 8'h39) begin
         char_class.is_sextet = 1'b1;
         char_class.sextet    = 6'(char_in - 8'h30 + 8'd52);
      end else if (char_in == pbd_pkg::CharPlus) begin
         char_class.is_sextet = 1'b1;
         char_class.sextet    = pbd_pkg::SextetPlus;
      end else if (char_in == pbd_pkg::CharSlash) begin
         char_class.is_sextet = 1'b1;
         char_class.sextet    = pbd_pkg::SextetSlash;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/pbd_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbd_parser
// Marker tracking and base64 group decoding. Holds the stream state and
// updates it when the registered input byte is consumed.
// ----------------------------------------------------------------------------
module pbd_parser (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic [7:0]             char_in,
   input  wire logic                   last,
   input  wire pbd_pkg::char_class_type char_class,
   output pbd_pkg::result_type         result
);

   pbd_pkg::phase_type phase_ff, phase_in;
   logic [3:0] marker_match_ff, marker_match_in;
   logic [2:0] end_match_ff, end_match_in;
   logic [1:0] group_pos_ff, group_pos_in;
   logic [5:0] prev_sextet_ff, prev_sextet_in;
   logic       pad_seen_ff, pad_seen_in;

   logic [3:0] begin_next;
   logic [2:0] end_next;

   always_comb begin
      // Begin marker matcher: on a mismatch a dash restarts the match, and
      // keeps five dashes matched when five are already matched.
      if (marker_match_ff < 4'(pbd_pkg::BeginLen) &&
          char_in == pbd_pkg::begin_char(marker_match_ff)) begin
         begin_next = marker_match_ff + 4'd1;
      end else if (char_class.is_dash) begin
         begin_next = (marker_match_ff == 4'd5) ? 4'd5 : 4'd1;
      end else begin
         begin_next = 4'd0;
      end

      if (end_match_ff >= 3'd1 && end_match_ff < 3'(pbd_pkg::EndLen) &&
          char_class.is_dash) begin
         end_next = end_match_ff + 3'd1;
      end else begin
         end_next = char_class.is_newline ? 3'd1 : 3'd0;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      marker_match_in = marker_match_ff;
      end_match_in    = end_match_ff;
      group_pos_in    = group_pos_ff;
      prev_sextet_in  = prev_sextet_ff;
      pad_seen_in     = pad_seen_ff;
      result          = '0;

      unique case (phase_ff)
         pbd_pkg::PHASE_SEEK: begin
            if (begin_next >= 4'(pbd_pkg::BeginLen)) begin
               phase_in        = pbd_pkg::PHASE_SKIPLINE;
               marker_match_in = 4'd0;
            end else begin
               marker_match_in = begin_next;
            end
         end
         pbd_pkg::PHASE_SKIPLINE: begin
            // The newline closing the header also starts the end marker.
            if (char_class.is_newline) begin
               phase_in     = pbd_pkg::PHASE_BODY;
               end_match_in = 3'd1;
            end
         end
         pbd_pkg::PHASE_BODY: begin
            end_match_in = end_next;
            if (end_next >= 3'(pbd_pkg::EndLen)) begin
               phase_in = pbd_pkg::PHASE_DONE;
            end else if (!pad_seen_ff) begin
               if (char_class.is_pad) begin
                  pad_seen_in = 1'b1;
               end else if (char_class.is_sextet) begin
                  unique case (group_pos_ff)
                     2'd1: begin
                        result.data_valid = 1'b1;
                        result.out_byte   = {prev_sextet_ff, char_class.sextet[5:4]};
                     end
                     2'd2: begin
                        result.data_valid = 1'b1;
                        result.out_byte   = {prev_sextet_ff[3:0], char_class.sextet[5:2]};
                     end
                     2'd3: begin
                        result.data_valid = 1'b1;
                        result.out_byte   = {prev_sextet_ff[1:0], char_class.sextet};
                     end
                     default: begin
                        result.data_valid = 1'b0;
                     end
                  endcase
                  prev_sextet_in = char_class.sextet;
                  group_pos_in   = group_pos_ff + 2'd1;
               end
            end
         end
         pbd_pkg::PHASE_DONE: begin
            // Everything after the end marker is ignored.
         end
         default: begin
            phase_in = pbd_pkg::PHASE_SEEK;
         end
      endcase

      if (last) begin
         result.done_res = 1'b1;
         if (phase_in == pbd_pkg::PHASE_SEEK) begin
            result.status = pbd_pkg::STATUS_NO_BEGIN;
         end else if (phase_in == pbd_pkg::PHASE_DONE) begin
            result.status = pbd_pkg::STATUS_OK;
         end else begin
            result.status = pbd_pkg::STATUS_NO_END;
         end
         phase_in        = pbd_pkg::PHASE_SEEK;
         marker_match_in = 4'd0;
         end_match_in    = 3'd0;
         group_pos_in    = 2'd0;
         prev_sextet_in  = 6'd0;
         pad_seen_in     = 1'b0;
      end

      result.present = result.data_valid | result.done_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= pbd_pkg::PHASE_SEEK;
         marker_match_ff <= 4'd0;
         end_match_ff    <= 3'd0;
         group_pos_ff    <= 2'd0;
         prev_sextet_ff  <= 6'd0;
         pad_seen_ff     <= 1'b0;
      end else if (step) begin
         phase_ff        <= phase_in;
         marker_match_ff <= marker_match_in;
         end_match_ff    <= end_match_in;
         group_pos_ff    <= group_pos_in;
         prev_sextet_ff  <= prev_sextet_in;
         pad_seen_ff     <= pad_seen_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/pbd_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbd_out_reg
// Result register of the decoder. Loads a result when it is empty or its
// current transaction completes in the same cycle.
// ----------------------------------------------------------------------------
module pbd_out_reg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire pbd_pkg::result_type result,
   output logic                     can_load,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_data_valid,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_done_res,
   output logic [1:0]               rsp_status
);

   logic       valid_ff, valid_in;
   logic       data_valid_ff;
   logic [7:0] out_byte_ff;
   logic       done_res_ff;
   logic [1:0] status_ff;

   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (can_load) begin
         valid_in = load && result.present;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (can_load && load && result.present) begin
         data_valid_ff <= result.data_valid;
         out_byte_ff   <= result.out_byte;
         done_res_ff   <= result.done_res;
         status_ff     <= result.status;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_data_valid = data_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_done_res   = done_res_ff;
   assign rsp_status     = status_ff;

endmodule
`default_nettype wire

// File: hw/rtl/pem_base64_stream_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pem_base64_stream_decoder_core
// Decodes the base64 body of PEM text, one text byte per transaction.
// ----------------------------------------------------------------------------
// The block takes one byte of text per clock cycle unless the result side
// stalls it. Each accepted byte is held in the input register and its result
// in the result register, with the marker matching and group decoding done
// in the logic between them. A byte yields a result only when it completes a
// decoded byte or carries the last flag; other bytes are consumed silently.
// The result of the last byte carries done_res and the final status (ok, no
// begin marker, no end marker), after which the decoder is ready for a new
// text. Back-pressure on the result side stalls the input only when the
// result register is full and not being taken.
// ----------------------------------------------------------------------------
module pem_base64_stream_decoder_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_char_in,
   input  wire logic       req_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_data_valid,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_done_res,
   output logic [1:0]      rsp_status
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_last_ff;
   logic       can_load;
   logic       step;

   pbd_pkg::char_class_type char_class;
   pbd_pkg::result_type     result;

   // The registered byte is consumed whenever the result register can load.
   assign step      = in_valid_ff && can_load;
   assign req_ready = !in_valid_ff || can_load;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_char_in;
         in_last_ff <= req_last;
      end
   end

   pbd_char_class u_char_class (
      .char_in    (in_char_ff),
      .char_class (char_class)
   );

   pbd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .char_in    (in_char_ff),
      .last       (in_last_ff),
      .char_class (char_class),
      .result     (result)
   );

   pbd_out_reg u_out_reg (
      .clock          (clock),
      .reset          (reset),
      .load           (step),
      .result         (result),
      .can_load       (can_load),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data_valid (rsp_data_valid),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_done_res   (rsp_done_res),
      .rsp_status     (rsp_status)
   );

   // A result that leaves the block always carries a byte or the end flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data_valid || rsp_done_res))
      else $error("result without data or done");

   // Status is only meaningful on the final transaction.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_done_res) |-> (rsp_status == pbd_pkg::STATUS_OK))
      else $error("status set on a result that is not final");

   // A byte held in the input register while the output stalls stays put.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !can_load) |=> (in_valid_ff && $stable(in_char_ff)
                                      && $stable(in_last_ff)))
      else $error("input register changed during a stall");

   // The output byte is zero unless the result carries decoded data.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data_valid) |-> (rsp_out_byte == 8'd0))
      else $error("out_byte set without data_valid");

endmodule
`default_nettype wire
